>>> sv/point_in_tetrahedron_test_unit_macros.svh
// Assertion macros shared by the point-in-tetrahedron test unit.
`ifndef POINT_IN_TETRAHEDRON_TEST_UNIT_MACROS_SVH
`define POINT_IN_TETRAHEDRON_TEST_UNIT_MACROS_SVH
`ifndef SYNTH
`define PTT_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ptt assertion failed");
`define PTT_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ptt assertion failed");
`else
`define PTT_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define PTT_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

>>> sv/ptt_pkg.sv
// Types and constants for the point-in-tetrahedron test unit.
package ptt_pkg;

    localparam int COORD_WIDTH = 16;
    localparam int FIELD_W     = 16;
    localparam int VOL_W       = 52;
    localparam int NUM_DETS    = 5;
    localparam int TAG_W       = 3;
    localparam int QUEUE_DEPTH = 2;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_TEST = 1'b1;

    typedef struct packed {
        logic                      opcode;
        logic [1:0]                vertex_index;
        logic signed [FIELD_W-1:0] coord_x;
        logic signed [FIELD_W-1:0] coord_y;
        logic signed [FIELD_W-1:0] coord_z;
    } t_in;

    typedef struct packed {
        logic                      inside_res;
        logic                      degenerate;
        logic signed [VOL_W-1:0]   six_signed_volume;
        logic signed [FIELD_W-1:0] box_min_x;
        logic signed [FIELD_W-1:0] box_min_y;
        logic signed [FIELD_W-1:0] box_min_z;
        logic signed [FIELD_W-1:0] box_max_x;
        logic signed [FIELD_W-1:0] box_max_y;
        logic signed [FIELD_W-1:0] box_max_z;
    } t_out;

endpackage

>>> sv/point_in_tetrahedron_test_unit.sv
// Top level of the point-in-tetrahedron test unit.
//
//  channel  | handshake           | payload
//  ---------+---------------------+--------------------------
//  request  | push / full         | i_item  (ptt_pkg::t_in)
//  result   | empty / pop         | o_result (ptt_pkg::t_out)
//
// A load request gives no result. A test request passes through the determinant
// engine: five determinants are issued in turn into a 5-stage multiplier
// pipeline, which drains before the result register loads.
// Up to two test jobs wait in the queue while the engine is busy.
// Reset is synchronous, active low; it clears the vertex store to zero.
// A stalled result holds in its register; the engine holds its finished job.
module point_in_tetrahedron_test_unit #(
    parameter int COORD_WIDTH = ptt_pkg::COORD_WIDTH
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          push,
    output logic          full,
    input  ptt_pkg::t_in  i_item,
    output logic          empty,
    input  logic          pop,
    output ptt_pkg::t_out o_result
);

    localparam int EW = 15 * COORD_WIDTH;

    logic          w_q_push, w_q_full, w_q_pop, w_q_empty;
    logic [EW-1:0] w_q_wdata, w_q_rdata;

    assign full = w_q_full;

    ptt_front #(.CW(COORD_WIDTH)) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push    (push),
        .i_item    (i_item),
        .i_q_full  (w_q_full),
        .o_q_push  (w_q_push),
        .o_q_entry (w_q_wdata)
    );

    ptt_queue #(.WIDTH(EW), .DEPTH(ptt_pkg::QUEUE_DEPTH)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (w_q_push),
        .i_wdata (w_q_wdata),
        .o_full  (w_q_full),
        .i_rd    (w_q_pop),
        .o_empty (w_q_empty),
        .o_rdata (w_q_rdata)
    );

    ptt_back #(.CW(COORD_WIDTH)) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_empty (w_q_empty),
        .i_q_entry (w_q_rdata),
        .o_q_pop   (w_q_pop),
        .i_pop     (pop),
        .o_empty   (empty),
        .o_res     (o_result)
    );

endmodule

>>> sv/ptt_front.sv
// Front end: accepts requests, keeps the vertex store, queues test jobs.
module ptt_front #(
    parameter int CW = ptt_pkg::COORD_WIDTH
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  ptt_pkg::t_in      i_item,
    input  logic              i_q_full,
    output logic              o_q_push,
    output logic [15*CW-1:0]  o_q_entry
);

    localparam int FW = ptt_pkg::FIELD_W;

    logic [CW-1:0]   w_px, w_py, w_pz;
    logic [3*CW-1:0] r_vert [4];
    logic            w_accept;

    generate
        if (CW <= FW) begin : g_narrow
            assign w_px = i_item.coord_x[CW-1:0];
            assign w_py = i_item.coord_y[CW-1:0];
            assign w_pz = i_item.coord_z[CW-1:0];
        end else begin : g_wide
            assign w_px = {{(CW-FW){1'b0}}, i_item.coord_x};
            assign w_py = {{(CW-FW){1'b0}}, i_item.coord_y};
            assign w_pz = {{(CW-FW){1'b0}}, i_item.coord_z};
        end
    endgenerate

    assign w_accept = i_push && !i_q_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 4; i++) begin
                r_vert[i] <= '0;
            end
        end else if (w_accept && i_item.opcode == ptt_pkg::OP_LOAD) begin
            r_vert[i_item.vertex_index] <= {w_pz, w_py, w_px};
        end
    end

    // snapshot the vertices with the point so later loads cannot disturb the job
    assign o_q_push  = w_accept && i_item.opcode == ptt_pkg::OP_TEST;
    assign o_q_entry = {w_pz, w_py, w_px, r_vert[3], r_vert[2], r_vert[1], r_vert[0]};

endmodule

>>> sv/ptt_queue.sv
// Short job queue between the front end and the determinant engine.
module ptt_queue #(
    parameter int WIDTH = 240,
    parameter int DEPTH = ptt_pkg::QUEUE_DEPTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_wr,
    input  logic [WIDTH-1:0] i_wdata,
    output logic             o_full,
    input  logic             i_rd,
    output logic             o_empty,
    output logic [WIDTH-1:0] o_rdata
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNTW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wptr, r_rptr;
    logic [CNTW-1:0]  r_count;
    logic [WIDTH-1:0] r_rdata;
    logic             w_wr, w_rd;

    assign o_full  = r_count == CNTW'(DEPTH);
    assign o_empty = r_count == '0;
    assign w_wr    = i_wr && !o_full;
    assign w_rd    = i_rd && !o_empty;
    assign o_rdata = r_rdata;

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wptr] <= i_wdata;
        end
        if (w_rd) begin
            r_rdata <= r_mem[r_rptr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (w_wr) begin
                r_wptr <= (r_wptr == PW'(DEPTH-1)) ? '0 : r_wptr + 1'b1;
            end
            if (w_rd) begin
                r_rptr <= (r_rptr == PW'(DEPTH-1)) ? '0 : r_rptr + 1'b1;
            end
            case ({w_wr, w_rd})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

>>> sv/ptt_back.sv
// Determinant engine: five determinants through a multiplier pipeline, result register.
`include "point_in_tetrahedron_test_unit_macros.svh"
module ptt_back #(
    parameter int CW = ptt_pkg::COORD_WIDTH
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_q_empty,
    input  logic [15*CW-1:0]  i_q_entry,
    output logic              o_q_pop,
    input  logic              i_pop,
    output logic              o_empty,
    output ptt_pkg::t_out     o_res
);

    localparam int DW   = CW + 1;
    localparam int PRW  = 2 * DW;
    localparam int MW   = PRW + 1;
    localparam int TW   = DW + MW;
    localparam int DETW = TW + 2;
    localparam int VW   = ptt_pkg::VOL_W;
    localparam int FW   = ptt_pkg::FIELD_W;
    localparam int TGW  = ptt_pkg::TAG_W;
    localparam logic [TGW-1:0] LAST_TAG = TGW'(ptt_pkg::NUM_DETS - 1);

    typedef enum logic [1:0] {ST_IDLE, ST_RUN, ST_DRAIN, ST_HOLD} t_state;

    function automatic logic signed [DW-1:0] f_sub(input logic [CW-1:0] x,
                                                   input logic [CW-1:0] y);
        f_sub = $signed({x[CW-1], x}) - $signed({y[CW-1], y});
    endfunction

    t_state r_state;
    logic [TGW-1:0] r_k;

    logic [3*CW-1:0] w_v [5];
    logic [3*CW-1:0] w_a, w_b, w_c, w_d;

    logic                  r_s1_v, r_s2_v, r_s3_v, r_s4_v, r_s5_v;
    logic [TGW-1:0]        r_s1_tag, r_s2_tag, r_s3_tag, r_s4_tag, r_s5_tag;
    logic signed [DW-1:0]  r_ex, r_ey, r_ez, r_fx, r_fy, r_fz, r_gx, r_gy, r_gz;
    logic signed [DW-1:0]  r_e2x, r_e2y, r_e2z, r_e3x, r_e3y, r_e3z;
    logic signed [PRW-1:0] r_p0, r_p1, r_p2, r_p3, r_p4, r_p5;
    logic signed [MW-1:0]  r_m0, r_m1, r_m2;
    logic signed [TW-1:0]  r_t0, r_t1, r_t2;
    logic signed [DETW-1:0] r_det, r_d0;
    logic                  r_ge, r_le;

    logic                  r_out_valid;
    ptt_pkg::t_out         r_out;
    ptt_pkg::t_out         w_res;
    logic                  w_load_out;
    logic signed [CW-1:0]  w_lo [3];
    logic signed [CW-1:0]  w_hi [3];
    logic signed [VW-1:0]  w_vol;
    logic                  w_d0_pos, w_d0_neg;

    always_comb begin
        for (int i = 0; i < 5; i++) begin
            w_v[i] = i_q_entry[i*3*CW +: 3*CW];
        end
        w_a = (r_k == TGW'(1)) ? w_v[4] : w_v[0];
        w_b = (r_k == TGW'(2)) ? w_v[4] : w_v[1];
        w_c = (r_k == TGW'(3)) ? w_v[4] : w_v[2];
        w_d = (r_k == TGW'(4)) ? w_v[4] : w_v[3];
    end

    assign o_q_pop    = (r_state == ST_IDLE) && !i_q_empty;
    assign w_load_out = (r_state == ST_HOLD) && (!r_out_valid || i_pop);

    // valid bits and control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_k         <= '0;
            r_s1_v      <= 1'b0;
            r_s2_v      <= 1'b0;
            r_s3_v      <= 1'b0;
            r_s4_v      <= 1'b0;
            r_s5_v      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_s1_v <= r_state == ST_RUN;
            r_s2_v <= r_s1_v;
            r_s3_v <= r_s2_v;
            r_s4_v <= r_s3_v;
            r_s5_v <= r_s4_v;
            case (r_state)
                ST_IDLE: begin
                    r_k <= '0;
                    if (!i_q_empty) begin
                        r_state <= ST_RUN;
                    end
                end
                ST_RUN: begin
                    r_k <= r_k + 1'b1;
                    if (r_k == LAST_TAG) begin
                        r_state <= ST_DRAIN;
                    end
                end
                ST_DRAIN: begin
                    if (r_s5_v && r_s5_tag == LAST_TAG) begin
                        r_state <= ST_HOLD;
                    end
                end
                ST_HOLD: begin
                    if (w_load_out) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
            if (w_load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_pop) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // datapath: differences, pair products, minors, triple products, sum
    always_ff @(posedge i_clk) begin
        r_s1_tag <= r_k;
        r_ex <= f_sub(w_b[0 +: CW], w_a[0 +: CW]);
        r_ey <= f_sub(w_b[CW +: CW], w_a[CW +: CW]);
        r_ez <= f_sub(w_b[2*CW +: CW], w_a[2*CW +: CW]);
        r_fx <= f_sub(w_c[0 +: CW], w_a[0 +: CW]);
        r_fy <= f_sub(w_c[CW +: CW], w_a[CW +: CW]);
        r_fz <= f_sub(w_c[2*CW +: CW], w_a[2*CW +: CW]);
        r_gx <= f_sub(w_d[0 +: CW], w_a[0 +: CW]);
        r_gy <= f_sub(w_d[CW +: CW], w_a[CW +: CW]);
        r_gz <= f_sub(w_d[2*CW +: CW], w_a[2*CW +: CW]);

        r_s2_tag <= r_s1_tag;
        r_e2x <= r_ex;
        r_e2y <= r_ey;
        r_e2z <= r_ez;
        r_p0  <= r_fy * r_gz;
        r_p1  <= r_fz * r_gy;
        r_p2  <= r_fz * r_gx;
        r_p3  <= r_fx * r_gz;
        r_p4  <= r_fx * r_gy;
        r_p5  <= r_fy * r_gx;

        r_s3_tag <= r_s2_tag;
        r_e3x <= r_e2x;
        r_e3y <= r_e2y;
        r_e3z <= r_e2z;
        r_m0  <= MW'(r_p0) - MW'(r_p1);
        r_m1  <= MW'(r_p2) - MW'(r_p3);
        r_m2  <= MW'(r_p4) - MW'(r_p5);

        r_s4_tag <= r_s3_tag;
        r_t0  <= r_e3x * r_m0;
        r_t1  <= r_e3y * r_m1;
        r_t2  <= r_e3z * r_m2;

        r_s5_tag <= r_s4_tag;
        r_det <= DETW'(r_t0) + DETW'(r_t1) + DETW'(r_t2);

        // collect signs; the vertex determinant arrives first
        if (r_s5_v) begin
            if (r_s5_tag == '0) begin
                r_d0 <= r_det;
                r_ge <= 1'b1;
                r_le <= 1'b1;
            end else begin
                r_ge <= r_ge && !r_det[DETW-1];
                r_le <= r_le && (r_det[DETW-1] || r_det == '0);
            end
        end
    end

    generate
        if (DETW > VW) begin : g_sat
            always_comb begin
                if (r_d0[DETW-1:VW-1] == '0 || r_d0[DETW-1:VW-1] == '1) begin
                    w_vol = r_d0[VW-1:0];
                end else if (r_d0[DETW-1]) begin
                    w_vol = {1'b1, {(VW-1){1'b0}}};
                end else begin
                    w_vol = {1'b0, {(VW-1){1'b1}}};
                end
            end
        end else begin : g_ext
            assign w_vol = VW'(r_d0);
        end
    endgenerate

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            w_lo[k] = $signed(w_v[0][k*CW +: CW]);
            w_hi[k] = $signed(w_v[0][k*CW +: CW]);
            for (int i = 1; i < 4; i++) begin
                if ($signed(w_v[i][k*CW +: CW]) < w_lo[k]) begin
                    w_lo[k] = $signed(w_v[i][k*CW +: CW]);
                end
                if ($signed(w_v[i][k*CW +: CW]) > w_hi[k]) begin
                    w_hi[k] = $signed(w_v[i][k*CW +: CW]);
                end
            end
        end
        w_d0_neg = r_d0[DETW-1];
        w_d0_pos = !r_d0[DETW-1] && (r_d0 != '0);
        w_res.inside_res        = (w_d0_pos && r_ge) || (w_d0_neg && r_le);
        w_res.degenerate        = r_d0 == '0;
        w_res.six_signed_volume = w_vol;
        w_res.box_min_x         = FW'(w_lo[0]);
        w_res.box_min_y         = FW'(w_lo[1]);
        w_res.box_min_z         = FW'(w_lo[2]);
        w_res.box_max_x         = FW'(w_hi[0]);
        w_res.box_max_y         = FW'(w_hi[1]);
        w_res.box_max_z         = FW'(w_hi[2]);
    end

    always_ff @(posedge i_clk) begin
        if (w_load_out) begin
            r_out <= w_res;
        end
    end

    assign o_empty = !r_out_valid;
    assign o_res   = r_out;

    `PTT_ASSERT_NXT(a_last_to_hold, i_clk, i_rst_n, r_s5_v && r_s5_tag == LAST_TAG, r_state == ST_HOLD)
    `PTT_ASSERT_IMP(a_deg_outside, i_clk, i_rst_n, r_out_valid, !(r_out.inside_res && r_out.degenerate))
    `PTT_ASSERT_IMP(a_idle_drained, i_clk, i_rst_n, r_state == ST_IDLE, !r_s1_v && !r_s2_v && !r_s3_v && !r_s4_v && !r_s5_v)

endmodule

>>> test/point_in_tetrahedron_test_unit_checker.sv
// Checker for the point-in-tetrahedron test unit: tracks vertices, predicts and compares results.
`timescale 1ns / 100ps
module point_in_tetrahedron_test_unit_checker (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  logic          i_full,
    input  ptt_pkg::t_in  i_item,
    input  logic          i_empty,
    input  logic          i_pop,
    input  ptt_pkg::t_out i_result,
    output int            o_errors,
    output int            o_pending
);

    typedef logic signed [63:0] t_wide;

    t_wide            vtx [4][3];
    ptt_pkg::t_out    expected_results [$];

    assign o_pending = expected_results.size();

    function automatic t_wide tet_volume6(t_wide a[3], t_wide b[3], t_wide c[3], t_wide d[3]);
        t_wide ex, ey, ez, fx, fy, fz, gx, gy, gz;
        ex = b[0] - a[0]; ey = b[1] - a[1]; ez = b[2] - a[2];
        fx = c[0] - a[0]; fy = c[1] - a[1]; fz = c[2] - a[2];
        gx = d[0] - a[0]; gy = d[1] - a[1]; gz = d[2] - a[2];
        return (ex * fy * gz + ey * fz * gx + ez * fx * gy)
             - (ez * fy * gx + ey * fx * gz + ex * fz * gy);
    endfunction

    function automatic ptt_pkg::t_out classify_point(t_wide p[3]);
        ptt_pkg::t_out r;
        t_wide d0, dk;
        t_wide q [4][3];
        t_wide lo, hi;
        logic  all_pos, all_neg;
        d0 = tet_volume6(vtx[0], vtx[1], vtx[2], vtx[3]);
        all_pos = 1'b1;
        all_neg = 1'b1;
        for (int i = 0; i < 4; i++) begin
            q = vtx;
            q[i] = p;
            dk = tet_volume6(q[0], q[1], q[2], q[3]);
            if (dk < 0) all_pos = 1'b0;
            if (dk > 0) all_neg = 1'b0;
        end
        r = '0;
        r.inside_res = (d0 > 0) ? all_pos : (d0 < 0) ? all_neg : 1'b0;
        r.degenerate = (d0 == 0);
        r.six_signed_volume = d0[ptt_pkg::VOL_W-1:0];
        for (int k = 0; k < 3; k++) begin
            lo = vtx[0][k];
            hi = vtx[0][k];
            for (int i = 1; i < 4; i++) begin
                if (vtx[i][k] < lo) lo = vtx[i][k];
                if (vtx[i][k] > hi) hi = vtx[i][k];
            end
            case (k)
                0: begin r.box_min_x = lo[15:0]; r.box_max_x = hi[15:0]; end
                1: begin r.box_min_y = lo[15:0]; r.box_max_y = hi[15:0]; end
                default: begin r.box_min_z = lo[15:0]; r.box_max_z = hi[15:0]; end
            endcase
        end
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_wide         p [3];
        ptt_pkg::t_out exp_r;
        if (!i_rst_n) begin
            for (int i = 0; i < 4; i++)
                for (int k = 0; k < 3; k++)
                    vtx[i][k] = 0;
            expected_results.delete();
            o_errors <= 0;
        end else begin
            if (i_pop && !i_empty) begin
                if (expected_results.size() == 0) begin
                    $display("%0t: unexpected result expected none actual %h", $time, i_result);
                    o_errors <= o_errors + 1;
                end else begin
                    exp_r = expected_results.pop_front();
                    if (exp_r !== i_result) begin
                        $display("%0t: mismatch expected %p actual %p", $time, exp_r, i_result);
                        o_errors <= o_errors + 1;
                    end
                end
            end
            if (i_push && !i_full) begin
                p[0] = t_wide'(i_item.coord_x);
                p[1] = t_wide'(i_item.coord_y);
                p[2] = t_wide'(i_item.coord_z);
                if (i_item.opcode == ptt_pkg::OP_LOAD)
                    vtx[i_item.vertex_index] = p;
                else
                    expected_results.push_back(classify_point(p));
            end
        end
    end
endmodule

>>> test/point_in_tetrahedron_test_unit_tb.sv
// Testbench top for the point-in-tetrahedron test unit: stimulus and verdict.
`timescale 1ns / 100ps
module point_in_tetrahedron_test_unit_tb;

    localparam int RANDOM_REQUESTS = 1750;
    localparam int CYCLE_LIMIT     = 400000;

    logic           i_clk = 1'b0;
    logic           i_rst_n = 1'b0;
    logic           push = 1'b0;
    logic           pop = 1'b0;
    logic           full, empty;
    ptt_pkg::t_in   item = '0;
    ptt_pkg::t_out  result;
    int             errors, pending;
    int             cycles = 0;
    logic           quiet = 1'b0;

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    point_in_tetrahedron_test_unit i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .push(push), .full(full), .i_item(item),
        .empty(empty), .pop(pop), .o_result(result)
    );

    point_in_tetrahedron_test_unit_checker i_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(push), .i_full(full), .i_item(item),
        .i_empty(empty), .i_pop(pop), .i_result(result), .o_errors(errors),
        .o_pending(pending)
    );

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // Stall the result side at random by holding pop low.
    int pop_hold = 0;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else if (pop_hold > 0) begin
            pop_hold <= pop_hold - 1;
            pop <= 1'b0;
        end else if (!quiet && $urandom_range(0, 5) == 0) begin
            pop_hold <= $urandom_range(0, 2);
            pop <= 1'b0;
        end else begin
            pop <= 1'b1;
        end
    end

    function automatic logic [15:0] rand_coord();
        case ($urandom_range(0, 9))
            0: return 16'h8000;
            1: return 16'h7fff;
            2: return 16'(int'($urandom_range(0, 8)) - 4);
            3, 4: return 16'(int'($urandom_range(0, 1024)) - 512);
            default: return 16'($urandom);
        endcase
    endfunction

    // Present one request and hold it until accepted; at random, insert a gap first.
    task automatic send_request(logic op, logic [1:0] idx, logic [15:0] x, logic [15:0] y,
                                logic [15:0] z);
        ptt_pkg::t_in r;
        if (!quiet && $urandom_range(0, 4) == 0) begin
            push <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
        r.opcode = op;
        r.vertex_index = idx;
        r.coord_x = x;
        r.coord_y = y;
        r.coord_z = z;
        push <= 1'b1;
        item <= r;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
    endtask

    task automatic load_tet(logic [15:0] c[4][3]);
        for (int i = 0; i < 4; i++)
            send_request(ptt_pkg::OP_LOAD, 2'(i), c[i][0], c[i][1], c[i][2]);
    endtask

    initial begin
        logic [15:0] c [4][3];
        logic [15:0] sp;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Unwritten vertices: all zero, degenerate.
        send_request(ptt_pkg::OP_TEST, 2'd3, 16'h0000, 16'h0000, 16'h0000);
        // Unit tetrahedron, positive orientation; inside, vertex, outside.
        c = '{'{16'd0, 16'd0, 16'd0}, '{16'd256, 16'd0, 16'd0},
              '{16'd0, 16'd256, 16'd0}, '{16'd0, 16'd0, 16'd256}};
        load_tet(c);
        send_request(ptt_pkg::OP_TEST, 2'd0, 16'd32, 16'd32, 16'd32);
        send_request(ptt_pkg::OP_TEST, 2'd1, 16'd256, 16'd0, 16'd0);
        send_request(ptt_pkg::OP_TEST, 2'd2, 16'd200, 16'd200, 16'd200);
        // Swap two vertices for negative orientation.
        send_request(ptt_pkg::OP_LOAD, 2'd1, 16'd0, 16'd256, 16'd0);
        send_request(ptt_pkg::OP_LOAD, 2'd2, 16'd256, 16'd0, 16'd0);
        send_request(ptt_pkg::OP_TEST, 2'd0, 16'd32, 16'd32, 16'd32);
        send_request(ptt_pkg::OP_TEST, 2'd0, 16'hffff, 16'd0, 16'd0);
        // Extreme corners.
        c = '{'{16'h8000, 16'h8000, 16'h8000}, '{16'h7fff, 16'h8000, 16'h8000},
              '{16'h8000, 16'h7fff, 16'h8000}, '{16'h8000, 16'h8000, 16'h7fff}};
        load_tet(c);
        send_request(ptt_pkg::OP_TEST, 2'd0, 16'h8000, 16'h8000, 16'h8000);
        send_request(ptt_pkg::OP_TEST, 2'd0, 16'h7fff, 16'h7fff, 16'h7fff);
        send_request(ptt_pkg::OP_TEST, 2'd0, 16'hc000, 16'hc000, 16'hc000);

        for (int n = 0; n < RANDOM_REQUESTS; n++) begin
            if (n > RANDOM_REQUESTS - 150) quiet = 1'b1;
            case ($urandom_range(0, 9))
                0: begin
                    // Flat set: all four vertices share one z.
                    sp = rand_coord();
                    for (int i = 0; i < 4; i++) begin
                        c[i][0] = rand_coord();
                        c[i][1] = rand_coord();
                        c[i][2] = sp;
                    end
                    load_tet(c);
                    n += 3;
                end
                1, 2: begin
                    for (int i = 0; i < 4; i++)
                        for (int k = 0; k < 3; k++) c[i][k] = rand_coord();
                    load_tet(c);
                    n += 3;
                end
                3: send_request(ptt_pkg::OP_LOAD, 2'($urandom), rand_coord(), rand_coord(),
                                rand_coord());
                4: begin
                    // Point at a vertex of the last full set loaded, on the boundary if none has changed since.
                    sp = 16'($urandom_range(0, 3));
                    send_request(ptt_pkg::OP_TEST, 2'($urandom), c[sp][0], c[sp][1],
                                 c[sp][2]);
                end
                5, 6: begin
                    // Centroid of the last full set loaded: inside when not flat.
                    send_request(ptt_pkg::OP_TEST, 2'($urandom),
                        16'((32'(signed'(c[0][0])) + signed'(c[1][0]) + signed'(c[2][0])
                             + signed'(c[3][0])) >>> 2),
                        16'((32'(signed'(c[0][1])) + signed'(c[1][1]) + signed'(c[2][1])
                             + signed'(c[3][1])) >>> 2),
                        16'((32'(signed'(c[0][2])) + signed'(c[1][2]) + signed'(c[2][2])
                             + signed'(c[3][2])) >>> 2));
                end
                default: send_request(ptt_pkg::OP_TEST, 2'($urandom), rand_coord(),
                                      rand_coord(), rand_coord());
            endcase
        end
        push <= 1'b0;

        while (pending != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        if (errors == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end
endmodule
